/* rtl/core/spi_pkg.sv */
// shared constants, types and log helper functions for the spectral peak interpolator
`default_nettype none
package spi_pkg;

	localparam int OUT_FRAC_BITS = 7;
	localparam int DIV_N = 55;
	localparam int Q16_FRAC = 16;
	localparam int Q24_FRAC = 24;

	localparam logic [1:0] METHOD_PARABOLIC = 2'd0;
	localparam logic [1:0] METHOD_GAUSS_Q16 = 2'd1;
	localparam logic [1:0] METHOD_GAUSS_Q24 = 2'd2;

	localparam logic [31:0] Q16_Y0 = 32'h000a65af;
	localparam logic [31:0] Q24_Y0 = 32'h0b17217f;
	localparam logic [31:0] CORR_BASE = 32'h80000000;

	localparam logic [31:0] NORM_LIMIT [5] = '{
		32'h00008000, 32'h00800000, 32'h08000000, 32'h20000000, 32'h40000000};
	localparam int NORM_SH [5] = '{16, 8, 4, 2, 1};
	localparam logic [31:0] Q16_NORM [5] = '{
		32'h000b1721, 32'h00058b91, 32'h0002c5c8, 32'h000162e4, 32'h0000b172};
	localparam logic [31:0] Q24_NORM [5] = '{
		32'h0b17217f, 32'h058b90c0, 32'h02c5c860, 32'h0162e430, 32'h00b17218};
	localparam logic [31:0] Q16_STEP [7] = '{
		32'h000067cd, 32'h00003920, 32'h00001e27, 32'h00000f85,
		32'h000007e1, 32'h000003f8, 32'h000001fe};
	localparam logic [31:0] Q24_STEP [7] = '{
		32'h0067cc90, 32'h00391ff0, 32'h001e2707, 32'h000f8518,
		32'h0007e0a7, 32'h0003f815, 32'h0001fe03};

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
	} log_t;

	function automatic log_t log_norm(input log_t a, input logic q24);
		log_t r;
		r = a;
		for (int i = 0; i < 5; i++) begin
			if (r.x < NORM_LIMIT[i]) begin
				r.x = r.x << NORM_SH[i];
				r.y = r.y - (q24 ? Q24_NORM[i] : Q16_NORM[i]);
			end
		end
		return r;
	endfunction

	function automatic log_t log_step(input log_t a, input int k, input logic q24);
		log_t r;
		logic [31:0] t;
		r = a;
		t = a.x + (a.x >> k);
		if (!t[31]) begin
			r.x = t;
			r.y = a.y - (q24 ? Q24_STEP[k-1] : Q16_STEP[k-1]);
		end
		return r;
	endfunction

	function automatic logic [31:0] log_corr(input log_t a, input logic q24);
		logic [31:0] d;
		d = CORR_BASE - a.x;
		return a.y - (q24 ? 32'($signed(d) >>> 7) : 32'($signed(d) >>> 15));
	endfunction

endpackage
`default_nettype wire

/* rtl/core/spectral_peak_interpolator.sv */
// top level of the spectral peak interpolator: log pipeline and pipelined divider
// Usage:
// An item (bin_index and the three energies) is taken at a clock edge where start
// is high and busy is low. busy is always low: the block is a pipeline and takes
// one word every cycle.
// The result word appears on peak_position with done high for exactly one cycle.
// The receiver cannot hold results off, and none is needed: the pipeline never
// stalls. The path runs through six stages of log and operand work (the first
// loaded at the edge that takes the item), a 55-stage restoring divider, one
// quotient bit a stage, and an output register.
// The method register is written through cfg_valid/cfg_ready/interp_method;
// cfg_ready is always high. Write it only while no items are in flight.
// Each item samples the method as it enters.
// Reset clears all valid bits and sets the method to Gaussian with the Q24 log.
`default_nettype none
module spectral_peak_interpolator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] bin_index,
	input  wire logic [15:0] peak_energy,
	input  wire logic [15:0] left_energy,
	input  wire logic [15:0] right_energy,
	output logic             done,
	output logic signed [24:0] peak_position,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  interp_method
);
	import spi_pkg::*;

	logic [1:0] method_q;

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [15:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic [15:0] e_s1, l_s1, r_s1, e_s2, l_s2, r_s2, e_s3, l_s3, r_s3;
	logic [15:0] e_s4, l_s4, r_s4, e_s5, l_s5, r_s5;
	logic        par_s1, par_s2, par_s3, par_s4, par_s5;
	logic        q24_s1, q24_s2, q24_s3, q24_s4, q24_s5;
	logic        app_s1, app_s2, app_s3, app_s4, app_s5;
	log_t        lg_s1 [3];
	log_t        lg_s2 [3];
	log_t        lg_s3 [3];
	log_t        lg_s4 [3];
	logic [31:0] ly_s5 [3];

	logic        vld_ds [0:DIV_N];
	logic [15:0] idx_ds [0:DIV_N];
	logic        par_ds [0:DIV_N];
	logic        q24_ds [0:DIV_N];
	logic        neg_ds [0:DIV_N];
	logic        zero_ds [0:DIV_N];
	logic [31:0] den_ds [0:DIV_N];
	logic [31:0] rem_ds [0:DIV_N];
	logic [DIV_N-1:0] num_ds [0:DIV_N];
	logic [31:0] quo_ds [0:DIV_N];

	logic [15:0] ein [3];
	logic        accept;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= METHOD_GAUSS_Q24;
		end else if (cfg_valid && cfg_ready) begin
			method_q <= interp_method;
		end
	end

	assign ein[0] = peak_energy;
	assign ein[1] = left_energy;
	assign ein[2] = right_energy;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// stage 1: log operand setup
	always_ff @(posedge clk) begin
		idx_s1 <= bin_index;
		e_s1 <= peak_energy;
		l_s1 <= left_energy;
		r_s1 <= right_energy;
		par_s1 <= (method_q == METHOD_PARABOLIC);
		q24_s1 <= (method_q != METHOD_GAUSS_Q16);
		app_s1 <= ({1'b0, left_energy} + {1'b0, right_energy}) < {peak_energy, 1'b0};
		for (int i = 0; i < 3; i++) begin
			if (method_q == METHOD_GAUSS_Q16) begin
				lg_s1[i].x <= ein[i][15] ? {16'h7fff, 16'h0000} : {ein[i], 16'h0000};
				lg_s1[i].y <= Q16_Y0;
			end else begin
				lg_s1[i].x <= {1'b0, ein[i], 15'h0000};
				lg_s1[i].y <= Q24_Y0;
			end
		end
	end

	// stages 2 to 5: normalize, seven steps, correction
	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1; idx_s3 <= idx_s2; idx_s4 <= idx_s3; idx_s5 <= idx_s4;
		e_s2 <= e_s1; e_s3 <= e_s2; e_s4 <= e_s3; e_s5 <= e_s4;
		l_s2 <= l_s1; l_s3 <= l_s2; l_s4 <= l_s3; l_s5 <= l_s4;
		r_s2 <= r_s1; r_s3 <= r_s2; r_s4 <= r_s3; r_s5 <= r_s4;
		par_s2 <= par_s1; par_s3 <= par_s2; par_s4 <= par_s3; par_s5 <= par_s4;
		q24_s2 <= q24_s1; q24_s3 <= q24_s2; q24_s4 <= q24_s3; q24_s5 <= q24_s4;
		app_s2 <= app_s1; app_s3 <= app_s2; app_s4 <= app_s3; app_s5 <= app_s4;
		for (int i = 0; i < 3; i++) begin
			lg_s2[i] <= log_norm(lg_s1[i], q24_s1);
			lg_s3[i] <= log_step(log_step(log_step(lg_s2[i], 1, q24_s2), 2, q24_s2),
				3, q24_s2);
			lg_s4[i] <= log_step(log_step(log_step(log_step(lg_s3[i], 4, q24_s3), 5,
				q24_s3), 6, q24_s3), 7, q24_s3);
			ly_s5[i] <= log_corr(lg_s4[i], q24_s4);
		end
	end

	// stage 6: divider operands as magnitudes and sign
	logic [31:0] g_diff, g_den;
	logic signed [17:0] p_diff;
	logic signed [18:0] p_den;
	logic [31:0] g_dmag, g_nmag;
	logic [17:0] p_nmag;
	logic [18:0] p_dmag;
	logic [DIV_N-1:0] n_mag;
	logic [31:0] d_mag;
	logic        n_neg, d_neg;

	always_comb begin
		g_diff = ly_s5[1] - ly_s5[2];
		g_den = ly_s5[1] + ly_s5[2] - {ly_s5[0][30:0], 1'b0};
		p_diff = $signed({2'b00, l_s5}) - $signed({2'b00, r_s5});
		p_den = $signed({3'b000, l_s5}) + $signed({3'b000, r_s5})
			- $signed({2'b00, e_s5, 1'b0});
		g_nmag = g_diff[31] ? (32'h0 - g_diff) : g_diff;
		g_dmag = g_den[31] ? (32'h0 - g_den) : g_den;
		p_nmag = p_diff[17] ? 18'(-p_diff) : 18'(p_diff);
		p_dmag = p_den[18] ? 19'(-p_den) : 19'(p_den);
		if (par_s5) begin
			n_mag = DIV_N'({p_nmag, 6'(0)}) << (OUT_FRAC_BITS - 1 - 6 + 6) >> 6;
			d_mag = 32'(p_dmag);
			n_neg = p_diff[17];
			d_neg = p_den[18];
		end else begin
			n_mag = q24_s5 ? (DIV_N'(g_nmag) << (Q24_FRAC - 1))
				: (DIV_N'(g_nmag) << (Q16_FRAC - 1));
			d_mag = g_dmag;
			n_neg = g_diff[31];
			d_neg = g_den[31];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_ds[0] <= 1'b0;
		end else begin
			vld_ds[0] <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		idx_ds[0] <= idx_s5;
		par_ds[0] <= par_s5;
		q24_ds[0] <= q24_s5;
		neg_ds[0] <= n_neg ^ d_neg;
		zero_ds[0] <= !app_s5 || (d_mag == 32'h0);
		den_ds[0] <= d_mag;
		rem_ds[0] <= 32'h0;
		num_ds[0] <= n_mag;
		quo_ds[0] <= 32'h0;
	end

	// restoring divider, one quotient bit a stage
	for (genvar j = 1; j <= DIV_N; j++) begin : g_div
		logic [32:0] trial;
		logic        ge;
		logic [32:0] diff;
		assign trial = {rem_ds[j-1], num_ds[j-1][DIV_N-1]};
		assign diff = trial - {1'b0, den_ds[j-1]};
		assign ge = !diff[32];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_ds[j] <= 1'b0;
			end else begin
				vld_ds[j] <= vld_ds[j-1];
			end
		end
		always_ff @(posedge clk) begin
			idx_ds[j] <= idx_ds[j-1];
			par_ds[j] <= par_ds[j-1];
			q24_ds[j] <= q24_ds[j-1];
			neg_ds[j] <= neg_ds[j-1];
			zero_ds[j] <= zero_ds[j-1];
			den_ds[j] <= den_ds[j-1];
			rem_ds[j] <= ge ? diff[31:0] : trial[31:0];
			num_ds[j] <= num_ds[j-1] << 1;
			quo_ds[j] <= {quo_ds[j-1][30:0], ge};
		end
	end

	// output stage: sign, scale, add bin offset
	logic [31:0] q_sgn, dx, pos;

	always_comb begin
		q_sgn = neg_ds[DIV_N] ? (32'h0 - quo_ds[DIV_N]) : quo_ds[DIV_N];
		if (zero_ds[DIV_N]) begin
			dx = 32'h0;
		end else if (par_ds[DIV_N]) begin
			dx = q_sgn;
		end else if (q24_ds[DIV_N]) begin
			dx = 32'($signed(q_sgn) >>> (Q24_FRAC - OUT_FRAC_BITS));
		end else begin
			dx = 32'($signed(q_sgn) >>> (Q16_FRAC - OUT_FRAC_BITS));
		end
		pos = (32'(idx_ds[DIV_N]) << OUT_FRAC_BITS) + dx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_ds[DIV_N];
		end
	end

	always_ff @(posedge clk) begin
		peak_position <= $signed(pos[24:0]);
	end

endmodule
`default_nettype wire
